// File: sv/cfdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfdc_pkg
// Shared types, codes and the CRC-32 byte step for the firmware download
// checker.
// ----------------------------------------------------------------------------
package cfdc_pkg;

    // Largest data chunk carried in one data frame
    localparam int MAX_CHUNK = 6;

    // Result queue geometry
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

    // Frame kinds
    localparam logic [2:0] KIND_PING   = 3'd0;
    localparam logic [2:0] KIND_START  = 3'd1;
    localparam logic [2:0] KIND_DATA   = 3'd2;
    localparam logic [2:0] KIND_END    = 3'd3;
    localparam logic [2:0] KIND_ABORT  = 3'd4;
    localparam logic [2:0] KIND_STATUS = 3'd5;

    // Emitted frame types
    localparam logic FTYPE_ACK    = 1'b0;
    localparam logic FTYPE_STATUS = 1'b1;

    // Ack result codes
    localparam logic [7:0] ACK_OK      = 8'd0;
    localparam logic [7:0] ACK_REFUSED = 8'd1;

    // Status state codes
    localparam logic [7:0] ST_ACTIVE = 8'd1;
    localparam logic [7:0] ST_DONE   = 8'd2;
    localparam logic [7:0] ST_FAIL   = 8'hFF;

    // Detail codes
    localparam logic [7:0] DET_NONE         = 8'd0;
    localparam logic [7:0] DET_NOT_UPDATE   = 8'd2;
    localparam logic [7:0] DET_DATA_LEN     = 8'd3;
    localparam logic [7:0] DET_CHUNK_LEN    = 8'd4;
    localparam logic [7:0] DET_OVERFLOW     = 8'd5;
    localparam logic [7:0] DET_PING_LEN     = 8'd10;
    localparam logic [7:0] DET_START_LEN    = 8'd11;
    localparam logic [7:0] DET_END_LEN      = 8'd12;
    localparam logic [7:0] DET_END_MISMATCH = 8'd13;
    localparam logic [7:0] DET_START_FLASH  = 8'd21;
    localparam logic [7:0] DET_END_STATE    = 8'd22;
    localparam logic [7:0] DET_CRC          = 8'd23;
    localparam logic [7:0] DET_END_FLASH    = 8'd24;
    localparam logic [7:0] DET_NO_SESSION   = 8'd26;
    localparam logic [7:0] DET_WRITE_FAIL   = 8'd27;
    localparam logic [7:0] DET_DISABLED     = 8'd99;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;

    // One received frame
    typedef struct packed {
        logic [2:0] frame_kind;
        logic [3:0] frame_length;
        logic [7:0] data_b0;
        logic [7:0] data_b1;
        logic [7:0] data_b2;
        logic [7:0] data_b3;
        logic [7:0] data_b4;
        logic [7:0] data_b5;
        logic [7:0] data_b6;
        logic [7:0] data_b7;
        logic       flash_ok;
    } frame_t;

    // One emitted result frame
    typedef struct packed {
        logic       frame_type;
        logic [7:0] out_b0;
        logic [7:0] out_b1;
        logic [7:0] out_b2;
        logic       mode_flag;
        logic [7:0] abort_echo;
        logic       restart_request;
        logic       last_of_run;
    } result_t;

    // Reflected CRC-32 over one byte (register kept inverted by caller)
    function automatic logic [31:0] crc_byte(input logic [31:0] c_in,
                                             input logic [7:0]  b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// File: sv/cfdc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfdc channel interfaces
// Valid/ready channels for received frames, result frames and the
// configuration write.
// ----------------------------------------------------------------------------
interface cfdc_frame_if;
    logic             valid;
    logic             ready;
    cfdc_pkg::frame_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cfdc_result_if;
    logic              valid;
    logic              ready;
    cfdc_pkg::result_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cfdc_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/can_firmware_download_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// can_firmware_download_checker
// Checks a CAN firmware download session frame by frame and answers with
// acknowledge and update-status frames.
// ----------------------------------------------------------------------------
// A received frame is decided combinationally: the session checks and the
// six-byte CRC-32 step are done in a single pass, and the session registers
// update at the accepting edge. Each frame yields zero, one or two result
// words, which enter a four-entry result queue; frame_in.ready is high
// whenever the queue has room for two words, so a new frame can be taken in
// every cycle while earlier results still wait. Results leave at one word per
// cycle while result_out.ready is high, so the read port sets the sustained
// rate: one frame per cycle for single-result frames, fewer for two. The
// update_enable register resets to 1; cfg writes it and is always ready.
// ----------------------------------------------------------------------------
module can_firmware_download_checker (
    input  wire              clk,
    input  wire              rst_n,
    cfdc_frame_if.sink       frame_in,
    cfdc_result_if.source    result_out,
    cfdc_cfg_if.sink         cfg
);

    // Session state
    logic        update_enable_reg;
    logic        update_mode_reg,   update_mode_next;
    logic        in_progress_reg,   in_progress_next;
    logic [31:0] image_size_reg,    image_size_next;
    logic [31:0] expected_crc_reg,  expected_crc_next;
    logic [31:0] byte_count_reg,    byte_count_next;
    logic [31:0] running_crc_reg,   running_crc_next;
    logic [7:0]  last_sequence_reg, last_sequence_next;
    logic [7:0]  abort_reason_reg,  abort_reason_next;
    logic [7:0]  ack_counter_reg,   ack_counter_next;

    // Result queue
    cfdc_pkg::result_t               rq_mem [cfdc_pkg::RQ_DEPTH];
    logic [cfdc_pkg::RQ_AW-1:0]      rq_wr_reg, rq_wr_next;
    logic [cfdc_pkg::RQ_AW-1:0]      rq_rd_reg, rq_rd_next;
    logic [cfdc_pkg::RQ_CW-1:0]      rq_cnt_reg, rq_cnt_next;

    cfdc_pkg::frame_t f;
    logic             accept;
    logic             pop;

    // Per-frame decision
    logic        emit_ack;
    logic [7:0]  ack_result;
    logic [7:0]  ack_detail;
    logic        emit_status;
    logic [7:0]  st_b0;
    logic [7:0]  st_b1;
    logic [7:0]  st_b2;
    logic        restart;
    logic [1:0]  n_res;
    cfdc_pkg::result_t ack_word;
    cfdc_pkg::result_t st_word;
    cfdc_pkg::result_t r0;
    cfdc_pkg::result_t r1;

    // Data frame fields
    logic [7:0]  chunk [cfdc_pkg::MAX_CHUNK];
    logic [7:0]  seq;
    logic [7:0]  clen;
    logic [7:0]  len_w;
    logic [32:0] count_sum;
    logic [31:0] crc_c;
    logic [31:0] crc_chunk;
    logic [31:0] total;
    logic        cnt_ok;
    logic        seq_ok;

    assign f      = frame_in.data;
    assign accept = frame_in.valid && frame_in.ready;
    assign pop    = result_out.valid && result_out.ready;

    // Take frames while two result slots are free
    assign frame_in.ready = (rq_cnt_reg <= cfdc_pkg::RQ_CW'(cfdc_pkg::RQ_DEPTH - 2));
    assign cfg.ready      = 1'b1;

    assign result_out.valid = (rq_cnt_reg != '0);
    assign result_out.data  = rq_mem[rq_rd_reg];

    // Gather data frame fields
    assign seq   = f.data_b0;
    assign clen  = f.data_b1;
    assign len_w = {4'd0, f.frame_length};
    assign chunk[0] = f.data_b2;
    assign chunk[1] = f.data_b3;
    assign chunk[2] = f.data_b4;
    assign chunk[3] = f.data_b5;
    assign chunk[4] = f.data_b6;
    assign chunk[5] = f.data_b7;
    assign count_sum = {1'b0, byte_count_reg} + {25'd0, clen};
    assign total  = {f.data_b4, f.data_b3, f.data_b2, f.data_b1};
    assign cnt_ok = (byte_count_reg == image_size_reg);
    assign seq_ok = (total != 32'd0) && (f.data_b0 == (total[7:0] - 8'd1));

    // Advance the running CRC over the chunk bytes
    always_comb
    begin
        crc_c = ~running_crc_reg;
        for (int i = 0; i < cfdc_pkg::MAX_CHUNK; i++) begin
            if (8'(i) < clen) begin
                crc_c = cfdc_pkg::crc_byte(crc_c, chunk[i]);
            end
        end
        crc_chunk = ~crc_c;
    end

    // Decide session update and answers for the offered frame
    always_comb
    begin
        update_mode_next   = update_mode_reg;
        in_progress_next   = in_progress_reg;
        image_size_next    = image_size_reg;
        expected_crc_next  = expected_crc_reg;
        byte_count_next    = byte_count_reg;
        running_crc_next   = running_crc_reg;
        last_sequence_next = last_sequence_reg;
        abort_reason_next  = abort_reason_reg;
        emit_ack    = 1'b0;
        ack_result  = cfdc_pkg::ACK_OK;
        ack_detail  = cfdc_pkg::DET_NONE;
        emit_status = 1'b0;
        st_b0       = cfdc_pkg::ST_FAIL;
        st_b1       = cfdc_pkg::DET_NONE;
        st_b2       = 8'd0;
        restart     = 1'b0;

        priority if (f.frame_kind == cfdc_pkg::KIND_PING) begin
            emit_ack = 1'b1;
            if (f.frame_length != 4'd8) begin
                ack_result = cfdc_pkg::ACK_REFUSED;
                ack_detail = cfdc_pkg::DET_PING_LEN;
            end
        end else if (f.frame_kind == cfdc_pkg::KIND_STATUS) begin
            if (f.frame_length == 4'd8) begin
                emit_status = 1'b1;
                st_b0 = {7'd0, update_mode_reg};
                st_b1 = cfdc_pkg::DET_NONE;
                st_b2 = last_sequence_reg;
            end
        end else if (f.frame_kind <= cfdc_pkg::KIND_ABORT && !update_enable_reg) begin
            emit_ack   = 1'b1;
            ack_result = cfdc_pkg::ACK_REFUSED;
            ack_detail = cfdc_pkg::DET_DISABLED;
        end else if (f.frame_kind == cfdc_pkg::KIND_START) begin
            emit_ack    = 1'b1;
            emit_status = 1'b1;
            if (f.frame_length != 4'd8) begin
                ack_result = cfdc_pkg::ACK_REFUSED;
                ack_detail = cfdc_pkg::DET_START_LEN;
            end else begin
                image_size_next    = {f.data_b3, f.data_b2, f.data_b1, f.data_b0};
                expected_crc_next  = {f.data_b7, f.data_b6, f.data_b5, f.data_b4};
                byte_count_next    = 32'd0;
                running_crc_next   = 32'd0;
                last_sequence_next = 8'd0;
                abort_reason_next  = 8'd0;
                in_progress_next   = 1'b0;
                if (!f.flash_ok) begin
                    ack_result = cfdc_pkg::ACK_REFUSED;
                    ack_detail = cfdc_pkg::DET_START_FLASH;
                end else begin
                    in_progress_next = 1'b1;
                    update_mode_next = 1'b1;
                    st_b0 = cfdc_pkg::ST_ACTIVE;
                end
            end
            st_b1 = ack_detail;
        end else if (f.frame_kind == cfdc_pkg::KIND_DATA) begin
            emit_ack    = 1'b1;
            emit_status = 1'b1;
            ack_result  = cfdc_pkg::ACK_REFUSED;
            priority if (!update_mode_reg) begin
                ack_detail = cfdc_pkg::DET_NOT_UPDATE;
            end else if (f.frame_length < 4'd2 || f.frame_length > 4'd8) begin
                ack_detail = cfdc_pkg::DET_DATA_LEN;
            end else if (clen == 8'd0 || clen > 8'(cfdc_pkg::MAX_CHUNK)
                         || clen > (len_w - 8'd2)) begin
                ack_detail = cfdc_pkg::DET_CHUNK_LEN;
                st_b2      = seq;
            end else if (count_sum > {1'b0, image_size_reg}) begin
                ack_detail = cfdc_pkg::DET_OVERFLOW;
                st_b2      = seq;
            end else begin
                byte_count_next    = count_sum[31:0];
                running_crc_next   = crc_chunk;
                last_sequence_next = seq;
                st_b2              = seq;
                priority if (!in_progress_reg) begin
                    ack_detail = cfdc_pkg::DET_NO_SESSION;
                end else if (!f.flash_ok) begin
                    in_progress_next = 1'b0;
                    ack_detail       = cfdc_pkg::DET_WRITE_FAIL;
                end else begin
                    ack_result = cfdc_pkg::ACK_OK;
                    st_b0      = cfdc_pkg::ST_ACTIVE;
                end
            end
            st_b1 = ack_detail;
        end else if (f.frame_kind == cfdc_pkg::KIND_END) begin
            emit_ack    = 1'b1;
            emit_status = 1'b1;
            ack_result  = cfdc_pkg::ACK_REFUSED;
            priority if (!update_mode_reg || !in_progress_reg) begin
                ack_detail = cfdc_pkg::DET_END_STATE;
            end else if (f.frame_length < 4'd5 || f.frame_length > 4'd8) begin
                ack_detail = cfdc_pkg::DET_END_LEN;
            end else if (!cnt_ok || !seq_ok) begin
                ack_detail = cfdc_pkg::DET_END_MISMATCH;
                st_b2      = f.data_b0;
            end else if (running_crc_reg != expected_crc_reg) begin
                in_progress_next = 1'b0;
                ack_detail       = cfdc_pkg::DET_CRC;
                st_b2            = f.data_b0;
            end else if (!f.flash_ok) begin
                in_progress_next = 1'b0;
                ack_detail       = cfdc_pkg::DET_END_FLASH;
                st_b2            = f.data_b0;
            end else begin
                in_progress_next = 1'b0;
                update_mode_next = 1'b0;
                restart          = 1'b1;
                ack_result       = cfdc_pkg::ACK_OK;
                st_b0            = cfdc_pkg::ST_DONE;
                st_b2            = f.data_b0;
            end
            st_b1 = ack_detail;
        end else if (f.frame_kind == cfdc_pkg::KIND_ABORT) begin
            if (f.frame_length == 4'd8) begin
                abort_reason_next = f.data_b0;
                byte_count_next   = 32'd0;
                in_progress_next  = 1'b0;
                update_mode_next  = 1'b0;
                emit_status       = 1'b1;
                st_b0             = cfdc_pkg::ST_FAIL;
                st_b1             = f.data_b0;
                st_b2             = 8'd0;
            end
        end else begin
            // Unknown kind: drop silently
            emit_ack    = 1'b0;
            emit_status = 1'b0;
        end
    end

    // Build result words in ack-then-status order
    always_comb
    begin
        ack_word.frame_type      = cfdc_pkg::FTYPE_ACK;
        ack_word.out_b0          = ack_counter_reg;
        ack_word.out_b1          = ack_result;
        ack_word.out_b2          = ack_detail;
        ack_word.mode_flag       = 1'b0;
        ack_word.abort_echo      = 8'd0;
        ack_word.restart_request = restart;
        ack_word.last_of_run     = !emit_status;

        st_word.frame_type      = cfdc_pkg::FTYPE_STATUS;
        st_word.out_b0          = st_b0;
        st_word.out_b1          = st_b1;
        st_word.out_b2          = st_b2;
        st_word.mode_flag       = update_mode_next;
        st_word.abort_echo      = abort_reason_next;
        st_word.restart_request = restart;
        st_word.last_of_run     = 1'b1;

        r0    = emit_ack ? ack_word : st_word;
        r1    = st_word;
        n_res = {1'b0, emit_ack} + {1'b0, emit_status};
        ack_counter_next = ack_counter_reg + {7'd0, emit_ack};
    end

    // Advance queue pointers and count
    always_comb
    begin
        rq_wr_next  = rq_wr_reg;
        rq_rd_next  = rq_rd_reg;
        rq_cnt_next = rq_cnt_reg;
        if (accept) begin
            rq_wr_next  = rq_wr_reg + cfdc_pkg::RQ_AW'(n_res);
            rq_cnt_next = rq_cnt_next + cfdc_pkg::RQ_CW'(n_res);
        end
        if (pop) begin
            rq_rd_next  = rq_rd_reg + cfdc_pkg::RQ_AW'(1);
            rq_cnt_next = rq_cnt_next - cfdc_pkg::RQ_CW'(1);
        end
    end

    // Write result words into the queue
    always_ff @(posedge clk)
    begin
        if (accept && n_res != 2'd0) begin
            rq_mem[rq_wr_reg] <= r0;
        end
        if (accept && n_res == 2'd2) begin
            rq_mem[rq_wr_reg + cfdc_pkg::RQ_AW'(1)] <= r1;
        end
    end

    // Hold control and session state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            update_enable_reg <= 1'b1;
            update_mode_reg   <= 1'b0;
            in_progress_reg   <= 1'b0;
            image_size_reg    <= 32'd0;
            expected_crc_reg  <= 32'd0;
            byte_count_reg    <= 32'd0;
            running_crc_reg   <= 32'd0;
            last_sequence_reg <= 8'd0;
            abort_reason_reg  <= 8'd0;
            ack_counter_reg   <= 8'd0;
            rq_wr_reg         <= '0;
            rq_rd_reg         <= '0;
            rq_cnt_reg        <= '0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                update_enable_reg <= cfg.data;
            end
            if (accept) begin
                update_mode_reg   <= update_mode_next;
                in_progress_reg   <= in_progress_next;
                image_size_reg    <= image_size_next;
                expected_crc_reg  <= expected_crc_next;
                byte_count_reg    <= byte_count_next;
                running_crc_reg   <= running_crc_next;
                last_sequence_reg <= last_sequence_next;
                abort_reason_reg  <= abort_reason_next;
                ack_counter_reg   <= ack_counter_next;
            end
            rq_wr_reg  <= rq_wr_next;
            rq_rd_reg  <= rq_rd_next;
            rq_cnt_reg <= rq_cnt_next;
        end
    end

endmodule
`default_nettype wire

// File: tb/sv/cfdc_answer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfdc_answer_checker
// Watches the frame, result and configuration channels of the firmware
// download checker. Keeps its own copy of the session state, predicts the
// ack and status words that each accepted frame causes, and compares every
// accepted result word against the oldest pending prediction.
// ----------------------------------------------------------------------------
package cfdc_tb_pkg;

    // Advance a zlib-style CRC-32 value by one byte
    function automatic logic [31:0] crc32_add_byte(input logic [31:0] crc,
                                                   input logic [7:0]  b);
        logic [31:0] c;
        c = ~crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ cfdc_pkg::CRC_POLY;
            else
                c = c >> 1;
        end
        return ~c;
    endfunction

endpackage

module cfdc_answer_checker (
    input  wire     clk,
    input  wire     rst_n,
    cfdc_frame_if   frame_mon,
    cfdc_result_if  result_mon,
    cfdc_cfg_if     cfg_mon,
    output int      mismatch_count,
    output int      answers_pending
);
    import cfdc_pkg::*;
    import cfdc_tb_pkg::*;

    // Predicted session state
    logic        update_enable_copy;
    logic        in_update;
    logic        session_open;
    logic        restart_now;
    logic [31:0] image_bytes;
    logic [31:0] target_crc;
    logic [31:0] received_bytes;
    logic [31:0] image_crc;
    logic [7:0]  last_seq;
    logic [7:0]  abort_code;
    logic [7:0]  ack_seq;

    result_t pending_answers[$];
    result_t frame_answers[$];

    initial mismatch_count = 0;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic reset_predictor();
        update_enable_copy = 1'b1;
        in_update          = 1'b0;
        session_open       = 1'b0;
        restart_now        = 1'b0;
        image_bytes        = '0;
        target_crc         = '0;
        received_bytes     = '0;
        image_crc          = '0;
        last_seq           = '0;
        abort_code         = '0;
        ack_seq            = '0;
        pending_answers.delete();
    endtask

    task automatic emit_ack(input logic [7:0] res, input logic [7:0] det);
        result_t r;
        r                 = '0;
        r.frame_type      = FTYPE_ACK;
        r.out_b0          = ack_seq;
        r.out_b1          = res;
        r.out_b2          = det;
        r.restart_request = restart_now;
        frame_answers.push_back(r);
        ack_seq = ack_seq + 8'd1;
    endtask

    task automatic emit_status(input logic [7:0] st, input logic [7:0] det,
                               input logic [7:0] echo);
        result_t r;
        r                 = '0;
        r.frame_type      = FTYPE_STATUS;
        r.out_b0          = st;
        r.out_b1          = det;
        r.out_b2          = echo;
        r.mode_flag       = in_update;
        r.abort_echo      = abort_code;
        r.restart_request = restart_now;
        frame_answers.push_back(r);
    endtask

    // Refusal: ack with the detail, then a fail status echoing it
    task automatic emit_refusal(input logic [7:0] det, input logic [7:0] echo);
        emit_ack(ACK_REFUSED, det);
        emit_status(ST_FAIL, det, echo);
    endtask

    // Work out the answer words of one received frame and queue them
    task automatic predict_answers(input frame_t f);
        logic [7:0]  chunk [MAX_CHUNK];
        logic [7:0]  seq;
        logic [7:0]  clen;
        logic [7:0]  lseq;
        logic [31:0] total;
        logic        count_ok;
        logic        seq_ok;
        frame_answers.delete();
        restart_now = 1'b0;
        chunk[0] = f.data_b2;
        chunk[1] = f.data_b3;
        chunk[2] = f.data_b4;
        chunk[3] = f.data_b5;
        chunk[4] = f.data_b6;
        chunk[5] = f.data_b7;

        if (f.frame_kind == KIND_PING) begin
            if (f.frame_length != 4'd8)
                emit_ack(ACK_REFUSED, DET_PING_LEN);
            else
                emit_ack(ACK_OK, DET_NONE);
        end
        else if (f.frame_kind == KIND_STATUS) begin
            if (f.frame_length == 4'd8)
                emit_status({7'd0, in_update}, DET_NONE, last_seq);
        end
        else if (f.frame_kind <= KIND_ABORT && !update_enable_copy) begin
            emit_ack(ACK_REFUSED, DET_DISABLED);
        end
        else if (f.frame_kind == KIND_START) begin
            if (f.frame_length != 4'd8) begin
                emit_refusal(DET_START_LEN, 8'd0);
            end
            else begin
                // Load the session even when the flash refuses to begin
                image_bytes    = {f.data_b3, f.data_b2, f.data_b1, f.data_b0};
                target_crc     = {f.data_b7, f.data_b6, f.data_b5, f.data_b4};
                received_bytes = '0;
                image_crc      = '0;
                last_seq       = '0;
                abort_code     = '0;
                session_open   = 1'b0;
                if (!f.flash_ok) begin
                    emit_refusal(DET_START_FLASH, 8'd0);
                end
                else begin
                    session_open = 1'b1;
                    in_update    = 1'b1;
                    emit_ack(ACK_OK, DET_NONE);
                    emit_status(ST_ACTIVE, DET_NONE, 8'd0);
                end
            end
        end
        else if (f.frame_kind == KIND_DATA) begin
            seq  = f.data_b0;
            clen = f.data_b1;
            if (!in_update) begin
                emit_refusal(DET_NOT_UPDATE, 8'd0);
            end
            else if (f.frame_length < 4'd2 || f.frame_length > 4'd8) begin
                emit_refusal(DET_DATA_LEN, 8'd0);
            end
            else if (clen == 8'd0 || clen > MAX_CHUNK
                     || int'(clen) > int'(f.frame_length) - 2) begin
                emit_refusal(DET_CHUNK_LEN, seq);
            end
            else if (33'(received_bytes) + 33'(clen) > 33'(image_bytes)) begin
                emit_refusal(DET_OVERFLOW, seq);
            end
            else begin
                // Count and CRC advance before the session checks
                received_bytes = received_bytes + 32'(clen);
                for (int i = 0; i < int'(clen); i++)
                    image_crc = crc32_add_byte(image_crc, chunk[i]);
                last_seq = seq;
                if (!session_open) begin
                    emit_refusal(DET_NO_SESSION, seq);
                end
                else if (!f.flash_ok) begin
                    session_open = 1'b0;
                    emit_refusal(DET_WRITE_FAIL, seq);
                end
                else begin
                    emit_ack(ACK_OK, DET_NONE);
                    emit_status(ST_ACTIVE, DET_NONE, seq);
                end
            end
        end
        else if (f.frame_kind == KIND_END) begin
            if (!in_update || !session_open) begin
                emit_refusal(DET_END_STATE, 8'd0);
            end
            else if (f.frame_length < 4'd5 || f.frame_length > 4'd8) begin
                emit_refusal(DET_END_LEN, 8'd0);
            end
            else begin
                lseq     = f.data_b0;
                total    = {f.data_b4, f.data_b3, f.data_b2, f.data_b1};
                count_ok = (received_bytes == image_bytes);
                seq_ok   = (total != 32'd0) && (lseq == 8'(total - 32'd1));
                if (!count_ok || !seq_ok) begin
                    emit_refusal(DET_END_MISMATCH, lseq);
                end
                else if (image_crc != target_crc) begin
                    session_open = 1'b0;
                    emit_refusal(DET_CRC, lseq);
                end
                else if (!f.flash_ok) begin
                    session_open = 1'b0;
                    emit_refusal(DET_END_FLASH, lseq);
                end
                else begin
                    session_open = 1'b0;
                    in_update    = 1'b0;
                    restart_now  = 1'b1;
                    emit_ack(ACK_OK, DET_NONE);
                    emit_status(ST_DONE, DET_NONE, lseq);
                end
            end
        end
        else if (f.frame_kind == KIND_ABORT) begin
            if (f.frame_length == 4'd8) begin
                abort_code     = f.data_b0;
                received_bytes = '0;
                session_open   = 1'b0;
                in_update      = 1'b0;
                emit_status(ST_FAIL, abort_code, 8'd0);
            end
        end

        // Mark the last word of this frame and hand the batch on
        if (frame_answers.size() > 0)
            frame_answers[frame_answers.size() - 1].last_of_run = 1'b1;
        foreach (frame_answers[i])
            pending_answers.push_back(frame_answers[i]);
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic check_answer(input result_t got);
        result_t want;
        if (pending_answers.size() == 0) begin
            report_mismatch($sformatf("result word %h with nothing pending", got));
        end
        else begin
            want = pending_answers.pop_front();
            compare_field("frame_type",      got.frame_type,      want.frame_type);
            compare_field("out_b0",          got.out_b0,          want.out_b0);
            compare_field("out_b1",          got.out_b1,          want.out_b1);
            compare_field("out_b2",          got.out_b2,          want.out_b2);
            compare_field("mode_flag",       got.mode_flag,       want.mode_flag);
            compare_field("abort_echo",      got.abort_echo,      want.abort_echo);
            compare_field("restart_request", got.restart_request, want.restart_request);
            compare_field("last_of_run",     got.last_of_run,     want.last_of_run);
        end
    endtask

    // Sample every channel at the rising edge
    always @(posedge clk) begin
        if (!rst_n) begin
            reset_predictor();
        end
        else begin
            if (cfg_mon.valid && cfg_mon.ready)
                update_enable_copy = cfg_mon.data;
            if (result_mon.valid && result_mon.ready)
                check_answer(result_mon.data);
            if (frame_mon.valid && frame_mon.ready)
                predict_answers(frame_mon.data);
        end
        answers_pending = pending_answers.size();
    end

endmodule

// File: tb/sv/tb_can_firmware_download_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_can_firmware_download_checker
// Drives received CAN frames into the firmware download checker: a directed
// walk through all refusal paths but the CRC and disabled ones, then random
// download sessions mixed with noise frames, with update_enable toggled between
// phases. Both channels idle at random; the checker beside the block compares.
// ----------------------------------------------------------------------------
module tb_can_firmware_download_checker;
    import cfdc_pkg::*;
    import cfdc_tb_pkg::*;

    localparam int         HALF_PERIOD = 5;
    localparam logic [2:0] KIND_UNUSED = 3'd7;

    logic clk;
    logic rst_n;
    int   items_sent;
    int   mismatch_count;
    int   answers_pending;
    logic sender_burst;
    logic reader_burst;

    cfdc_frame_if  frame_ch ();
    cfdc_result_if result_ch ();
    cfdc_cfg_if    cfg_ch ();

    can_firmware_download_checker i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_in   (frame_ch),
        .result_out (result_ch),
        .cfg        (cfg_ch)
    );

    cfdc_answer_checker i_answer_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .frame_mon       (frame_ch),
        .result_mon      (result_ch),
        .cfg_mon         (cfg_ch),
        .mismatch_count  (mismatch_count),
        .answers_pending (answers_pending)
    );

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // Fully random frame, mostly with a full length code
    function automatic frame_t noise_frame();
        frame_t f;
        f.frame_kind   = 3'($urandom_range(0, 7));
        f.frame_length = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
        f.data_b0      = 8'($urandom);
        f.data_b1      = 8'($urandom);
        f.data_b2      = 8'($urandom);
        f.data_b3      = 8'($urandom);
        f.data_b4      = 8'($urandom);
        f.data_b5      = 8'($urandom);
        f.data_b6      = 8'($urandom);
        f.data_b7      = 8'($urandom);
        f.flash_ok     = 1'($urandom);
        return f;
    endfunction

    function automatic frame_t plain_frame(input logic [2:0] kind, input logic [3:0] len,
                                           input logic ok);
        frame_t f;
        f              = noise_frame();
        f.frame_kind   = kind;
        f.frame_length = len;
        f.flash_ok     = ok;
        return f;
    endfunction

    function automatic frame_t start_frame(input logic [31:0] size, input logic [31:0] crc,
                                           input logic ok);
        frame_t f;
        f         = plain_frame(KIND_START, 4'd8, ok);
        f.data_b0 = size[7:0];
        f.data_b1 = size[15:8];
        f.data_b2 = size[23:16];
        f.data_b3 = size[31:24];
        f.data_b4 = crc[7:0];
        f.data_b5 = crc[15:8];
        f.data_b6 = crc[23:16];
        f.data_b7 = crc[31:24];
        return f;
    endfunction

    // Chunk byte i sits at chunk[8*i +: 8]
    function automatic frame_t data_frame(input logic [7:0] seq, input logic [7:0] clen,
                                          input logic [3:0] len, input logic [47:0] chunk,
                                          input logic ok);
        frame_t f;
        f         = plain_frame(KIND_DATA, len, ok);
        f.data_b0 = seq;
        f.data_b1 = clen;
        f.data_b2 = chunk[7:0];
        f.data_b3 = chunk[15:8];
        f.data_b4 = chunk[23:16];
        f.data_b5 = chunk[31:24];
        f.data_b6 = chunk[39:32];
        f.data_b7 = chunk[47:40];
        return f;
    endfunction

    function automatic frame_t end_frame(input logic [7:0] lseq, input logic [31:0] total,
                                         input logic [3:0] len, input logic ok);
        frame_t f;
        f         = plain_frame(KIND_END, len, ok);
        f.data_b0 = lseq;
        f.data_b1 = total[7:0];
        f.data_b2 = total[15:8];
        f.data_b3 = total[23:16];
        f.data_b4 = total[31:24];
        return f;
    endfunction

    // Offer one word after a random gap and hold it until taken
    task automatic send_frame(input frame_t f);
        int gap;
        @(negedge clk);
        if ($urandom_range(0, 39) == 0)
            sender_burst = !sender_burst;
        gap = sender_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            frame_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        frame_ch.data  <= f;
        frame_ch.valid <= 1'b1;
        do @(posedge clk); while (!(frame_ch.valid && frame_ch.ready));
        if (f.frame_kind <= KIND_STATUS)
            items_sent++;
    endtask

    // Hold off the sender until every predicted answer has come back
    task automatic drain_results();
        @(negedge clk);
        frame_ch.valid <= 1'b0;
        while (answers_pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_update_enable(input logic value);
        drain_results();
        cfg_ch.data  <= value;
        cfg_ch.valid <= 1'b1;
        do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Walk the refusal paths other than CRC and disabled, then a clean zero-byte image
    task automatic run_directed();
        frame_t      f;
        logic [31:0] crc;
        f = plain_frame(KIND_PING, 4'd8, 1'b1);
        {f.data_b0, f.data_b1, f.data_b2, f.data_b3} = '1;
        {f.data_b4, f.data_b5, f.data_b6, f.data_b7} = '1;
        send_frame(f);
        f = plain_frame(KIND_PING, 4'd0, 1'b0);
        {f.data_b0, f.data_b1, f.data_b2, f.data_b3} = '0;
        {f.data_b4, f.data_b5, f.data_b6, f.data_b7} = '0;
        send_frame(f);
        send_frame(plain_frame(KIND_UNUSED, 4'd15, 1'b1));
        send_frame(plain_frame(KIND_STATUS, 4'd8, 1'b1));
        send_frame(plain_frame(KIND_STATUS, 4'd0, 1'b1));
        send_frame(data_frame(8'd0, 8'd1, 4'd8, 48'({$urandom, $urandom}), 1'b1));
        send_frame(end_frame(8'd0, 32'd1, 4'd8, 1'b1));
        f = start_frame(32'd20, 32'd0, 1'b1);
        f.frame_length = 4'd15;
        send_frame(f);
        send_frame(start_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
        send_frame(start_frame(32'd20, 32'd0, 1'b1));
        send_frame(data_frame(8'd0, 8'd1, 4'd1, 48'({$urandom, $urandom}), 1'b1));
        send_frame(data_frame(8'd0, 8'd0, 4'd8, 48'({$urandom, $urandom}), 1'b1));
        send_frame(data_frame(8'd0, 8'd7, 4'd8, 48'({$urandom, $urandom}), 1'b1));
        send_frame(data_frame(8'd0, 8'd6, 4'd8, 48'({$urandom, $urandom}), 1'b1));
        // Flash write failure, then data with the session closed, then overflow
        send_frame(data_frame(8'd1, 8'd6, 4'd8, 48'({$urandom, $urandom}), 1'b0));
        send_frame(data_frame(8'd2, 8'd6, 4'd8, 48'({$urandom, $urandom}), 1'b1));
        send_frame(data_frame(8'd3, 8'd6, 4'd8, 48'({$urandom, $urandom}), 1'b1));
        send_frame(end_frame(8'd3, 32'd4, 4'd8, 1'b1));
        // Two-byte image: bad end length, zero total, end flash failure
        crc = crc32_add_byte(crc32_add_byte(32'd0, 8'h00), 8'hFF);
        send_frame(start_frame(32'd2, crc, 1'b1));
        send_frame(data_frame(8'd0, 8'd2, 4'd4, 48'h0000_0000_FF00, 1'b1));
        send_frame(end_frame(8'd0, 32'd1, 4'd4, 1'b1));
        send_frame(end_frame(8'hFF, 32'd0, 4'd8, 1'b1));
        send_frame(end_frame(8'd0, 32'd1, 4'd8, 1'b0));
        f = plain_frame(KIND_ABORT, 4'd8, 1'b1);
        f.data_b0 = 8'hA5;
        send_frame(f);
        send_frame(start_frame(32'd0, 32'd0, 1'b1));
        send_frame(end_frame(8'd0, 32'd1, 4'd5, 1'b1));
    endtask

    // One download: start, chunks of the image, end; with occasional faults
    task automatic run_download_session();
        logic [7:0]  image[$];
        logic [31:0] crc;
        logic [31:0] total;
        logic [47:0] chunk;
        frame_t      f;
        int          size;
        int          pos;
        int          clen;
        int          nchunks;
        size = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 48);
        crc  = '0;
        for (int i = 0; i < size; i++) begin
            image.push_back(8'($urandom));
            crc = crc32_add_byte(crc, image[i]);
        end
        if ($urandom_range(0, 7) == 0)
            crc = $urandom;
        send_frame(start_frame(32'(size), crc, $urandom_range(0, 15) != 0));

        pos     = 0;
        nchunks = 0;
        while (pos < size) begin
            if ($urandom_range(0, 19) == 0)
                send_frame(noise_frame());
            if ($urandom_range(0, 79) == 0) begin
                send_frame(plain_frame(KIND_ABORT, 4'd8, 1'b1));
                return;
            end
            clen  = $urandom_range(1, (size - pos < MAX_CHUNK) ? size - pos : MAX_CHUNK);
            chunk = 48'({$urandom, $urandom});
            for (int i = 0; i < clen; i++)
                chunk[8*i +: 8] = image[pos + i];
            f = data_frame(8'(nchunks), 8'(clen), 4'($urandom_range(clen + 2, 8)), chunk,
                           $urandom_range(0, 24) != 0);
            // Break the chunk length now and then
            if ($urandom_range(0, 39) == 0)
                f.data_b1 = 8'($urandom_range(0, 9));
            send_frame(f);
            pos += clen;
            nchunks++;
        end

        total = (nchunks != 0) ? 32'(nchunks) : 32'($urandom_range(1, 300));
        f = end_frame(8'(total - 32'd1), total, 4'($urandom_range(5, 8)),
                      $urandom_range(0, 15) != 0);
        if ($urandom_range(0, 15) == 0)
            f.data_b0 = f.data_b0 ^ 8'h01;
        send_frame(f);
    endtask

    task automatic random_phase(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) begin
            if ($urandom_range(0, 29) == 0)
                drain_results();
            if ($urandom_range(0, 9) < 7)
                run_download_session();
            else
                repeat ($urandom_range(1, 5)) send_frame(noise_frame());
        end
    endtask

    // Result side: random stall before each word, with stall-free stretches
    initial begin : result_reader
        int stall;
        result_ch.ready = 1'b0;
        reader_burst    = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if ($urandom_range(0, 39) == 0)
                reader_burst = !reader_burst;
            stall = reader_burst ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
        end
    end

    // Stimulus and verdict
    initial begin : stimulus
        rst_n          = 1'b0;
        frame_ch.valid = 1'b0;
        frame_ch.data  = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.data    = 1'b0;
        items_sent     = 0;
        sender_burst   = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_update_enable(1'b1);
        run_directed();
        random_phase(400);
        write_update_enable(1'b0);
        random_phase(120);
        write_update_enable(1'b1);
        random_phase(550);
        write_update_enable(1'b0);
        random_phase(40);
        write_update_enable(1'b1);
        random_phase(1250 - items_sent);

        drain_results();
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Give up on a hung handshake
    initial begin : watchdog
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
sv/cfdc_pkg.sv
sv/cfdc_if.sv
sv/can_firmware_download_checker.sv
tb/sv/cfdc_answer_checker.sv
tb/sv/tb_can_firmware_download_checker.sv
